FILE: design/roi_hist_pkg.sv
// Package with the shared types and constants of the ROI projection histogram.
package roi_hist_pkg;

  // Store depths and the widths that follow from them.
  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int ColAw     = $clog2(MaxWidth);
  localparam int RowAw     = $clog2(MaxHeight);
  localparam int ClrDepth  = (MaxWidth > MaxHeight) ? MaxWidth : MaxHeight;
  localparam int ClrW      = $clog2(ClrDepth);

  // Field widths.
  localparam int CoordW  = 10;
  localparam int PixelW  = 8;
  localparam int BinW    = 11;
  localparam int CfgIdxW = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_ROI_LEFT   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ROI_RIGHT  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ROI_TOP    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ROI_BOTTOM = 3'd3;

  typedef enum logic [1:0] {
    KIND_PIXEL    = 2'd0,
    KIND_CLEAR    = 2'd1,
    KIND_READ_COL = 2'd2,
    KIND_READ_ROW = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [PixelW-1:0]  pixel_value;
    logic [CoordW-1:0]  pixel_x;
    logic [CoordW-1:0]  pixel_y;
    logic [CoordW-1:0]  bin_select;
  } in_req_t;

  typedef struct packed {
    logic [BinW-1:0] bin_count;
    logic            bin_axis;
  } out_rsp_t;

endpackage

FILE: design/roi_projection_histogram_core.sv
// Top level of the ROI row and column projection histogram.
// Read path: a read request returns its bin through the memory read register, then the
// output register. Throughput: one request per cycle while no clearing pass runs and no
// read result stalls, set by the single write port of each bin memory with forwarding
// between back-to-back updates of the same bin. A clear request walks both bin memories,
// one entry per cycle. Reset is asynchronous, active low; it restores the region registers
// and starts the same clearing pass, during which no request is accepted.
module roi_projection_histogram_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [roi_hist_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [roi_hist_pkg::CoordW-1:0]   cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  roi_hist_pkg::in_req_t             in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output roi_hist_pkg::out_rsp_t            out_rsp_o
);
  import roi_hist_pkg::*;

  // Region registers.
  logic [CoordW-1:0] roi_left_q, roi_right_q, roi_top_q, roi_bottom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roi_left_q   <= '0;
      roi_right_q  <= '1;
      roi_top_q    <= '0;
      roi_bottom_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROI_LEFT:   roi_left_q   <= cfg_wdata_i;
        REG_ROI_RIGHT:  roi_right_q  <= cfg_wdata_i;
        REG_ROI_TOP:    roi_top_q    <= cfg_wdata_i;
        REG_ROI_BOTTOM: roi_bottom_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Bin memories.
  logic [BinW-1:0] col_mem [MaxWidth];
  logic [BinW-1:0] row_mem [MaxHeight];

  // Clearing pass state.
  logic            clr_active_q, clr_active_d;
  logic [ClrW-1:0] clr_cnt_q, clr_cnt_d;
  logic            clr_last;

  // Stage one: the request whose bins are being read.
  logic             s1_vld_q, s1_vld_d;
  kind_e            s1_kind_q;
  logic             s1_cnt_q;
  logic             s1_in_range_q;
  logic [ColAw-1:0] s1_col_addr_q;
  logic [RowAw-1:0] s1_row_addr_q;
  logic [BinW-1:0]  col_rd_q, row_rd_q;
  logic             col_fwd_q, row_fwd_q;
  logic [BinW-1:0]  col_fwd_val_q, row_fwd_val_q;

  // Output register.
  logic     out_vld_q, out_vld_d;
  out_rsp_t out_rsp_q;

  logic             accept;
  logic             s1_is_read;
  logic             s1_moves;
  logic             out_load;
  logic [CoordW-1:0] cx, ry;
  logic             in_roi;
  logic             pix_cnt;
  logic             sel_in_range;
  logic [ColAw-1:0] col_addr;
  logic [RowAw-1:0] row_addr;
  logic [BinW-1:0]  col_cur, row_cur;
  logic [BinW-1:0]  col_new, row_new;
  logic             pix_we;
  logic             col_we, row_we;
  logic [ColAw-1:0] col_wr_addr;
  logic [RowAw-1:0] row_wr_addr;
  logic [BinW-1:0]  col_wr_data, row_wr_data;

  // Handshake: a stalled read in stage one holds back new requests.
  assign s1_is_read = (s1_kind_q == KIND_READ_COL) || (s1_kind_q == KIND_READ_ROW);
  assign s1_moves   = !s1_is_read || !out_vld_q || out_ready_i;
  assign in_ready_o = !clr_active_q && (!s1_vld_q || s1_moves);
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = s1_vld_q && s1_is_read && (!out_vld_q || out_ready_i);

  // Region test and bin offsets of an incoming pixel.
  assign cx     = in_req_i.pixel_x - roi_left_q;
  assign ry     = in_req_i.pixel_y - roi_top_q;
  assign in_roi = (in_req_i.pixel_x >= roi_left_q) && (in_req_i.pixel_x <= roi_right_q) &&
                  (in_req_i.pixel_y >= roi_top_q) && (in_req_i.pixel_y <= roi_bottom_q);
  assign pix_cnt = (in_req_i.kind == KIND_PIXEL) && (in_req_i.pixel_value != '0) && in_roi &&
                   (int'(cx) < MaxWidth) && (int'(ry) < MaxHeight);

  // Read address: pixel offsets, or the selected bin for read requests.
  always_comb begin
    sel_in_range = 1'b0;
    col_addr     = ColAw'(cx);
    row_addr     = RowAw'(ry);
    case (in_req_i.kind)
      KIND_READ_COL: begin
        sel_in_range = int'(in_req_i.bin_select) < MaxWidth;
        col_addr     = ColAw'(in_req_i.bin_select);
      end
      KIND_READ_ROW: begin
        sel_in_range = int'(in_req_i.bin_select) < MaxHeight;
        row_addr     = RowAw'(in_req_i.bin_select);
      end
      default: ;
    endcase
  end

  // Current bin values, with the write of the previous pixel forwarded.
  assign col_cur = col_fwd_q ? col_fwd_val_q : col_rd_q;
  assign row_cur = row_fwd_q ? row_fwd_val_q : row_rd_q;
  assign col_new = (col_cur == '1) ? col_cur : col_cur + BinW'(1);
  assign row_new = (row_cur == '1) ? row_cur : row_cur + BinW'(1);
  assign pix_we  = s1_vld_q && (s1_kind_q == KIND_PIXEL) && s1_cnt_q;

  // Write port: the clearing pass or the pixel update.
  always_comb begin
    clr_last = clr_cnt_q == ClrW'(ClrDepth - 1);
    if (clr_active_q) begin
      col_we      = int'(clr_cnt_q) < MaxWidth;
      row_we      = int'(clr_cnt_q) < MaxHeight;
      col_wr_addr = ColAw'(clr_cnt_q);
      row_wr_addr = RowAw'(clr_cnt_q);
      col_wr_data = '0;
      row_wr_data = '0;
    end else begin
      col_we      = pix_we;
      row_we      = pix_we;
      col_wr_addr = s1_col_addr_q;
      row_wr_addr = s1_row_addr_q;
      col_wr_data = col_new;
      row_wr_data = row_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (col_we) begin
      col_mem[col_wr_addr] <= col_wr_data;
    end
    if (row_we) begin
      row_mem[row_wr_addr] <= row_wr_data;
    end
    if (accept) begin
      col_rd_q <= col_mem[col_addr];
      row_rd_q <= row_mem[row_addr];
    end
  end

  // Stage one payload, captured with the memory read.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q     <= in_req_i.kind;
      s1_cnt_q      <= pix_cnt;
      s1_in_range_q <= sel_in_range;
      s1_col_addr_q <= col_addr;
      s1_row_addr_q <= row_addr;
      col_fwd_q     <= pix_we && (s1_col_addr_q == col_addr);
      row_fwd_q     <= pix_we && (s1_row_addr_q == row_addr);
      col_fwd_val_q <= col_new;
      row_fwd_val_q <= row_new;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rsp_q.bin_axis <= (s1_kind_q == KIND_READ_ROW);
      if (!s1_in_range_q) begin
        out_rsp_q.bin_count <= '0;
      end else if (s1_kind_q == KIND_READ_ROW) begin
        out_rsp_q.bin_count <= row_cur;
      end else begin
        out_rsp_q.bin_count <= col_cur;
      end
    end
  end

  // Control next state.
  always_comb begin
    clr_active_d = clr_active_q;
    clr_cnt_d    = clr_cnt_q;
    if (clr_active_q) begin
      clr_cnt_d = clr_last ? '0 : clr_cnt_q + ClrW'(1);
      if (clr_last) begin
        clr_active_d = 1'b0;
      end
    end else if (accept && (in_req_i.kind == KIND_CLEAR)) begin
      clr_active_d = 1'b1;
      clr_cnt_d    = '0;
    end

    if (accept) begin
      s1_vld_d = in_req_i.kind != KIND_CLEAR;
    end else if (s1_moves) begin
      s1_vld_d = 1'b0;
    end else begin
      s1_vld_d = s1_vld_q;
    end

    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
      s1_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_cnt_q    <= clr_cnt_d;
      s1_vld_q     <= s1_vld_d;
      out_vld_q    <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_rsp_q;

  // The clearing pass and a request in flight never share the write port.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(clr_active_q && s1_vld_q))
    else $error("request in flight during clearing pass");

  // An accepted clear request starts the clearing pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   accept && (in_req_i.kind == KIND_CLEAR) |=> clr_active_q)
    else $error("clear request did not start the clearing pass");

  // A read that leaves stage one shows up in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_load |=> out_vld_q)
    else $error("read result lost");

  // A bin update only happens for a pixel request that is in stage one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (pix_we && !clr_active_q) |-> s1_vld_q && !s1_is_read)
    else $error("bin update without a pixel in stage one");

endmodule

FILE: sim/roi_projection_histogram_core_tb.sv
// Self-checking testbench for the ROI row and column projection histogram core.
`timescale 1ns / 1ps

module roi_projection_histogram_core_tb;
  import roi_hist_pkg::*;

  localparam int ClkHalfNs      = 2;
  localparam int ResetCycles    = 5;
  localparam int TimeoutNs      = 2_000_000;
  localparam int ClearWaitCycles = ClrDepth + 16;
  localparam int TailCycles     = 16;
  localparam int CoordMax       = (1 << CoordW) - 1;
  localparam int FirstUnusedReg = 4;
  localparam int SatPixels      = 2050;
  localparam logic [BinW-1:0]   BinFull   = '1;
  localparam logic [CoordW-1:0] CoordEdge = '1;

  // Ports of the block.
  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = '0;
  logic [CoordW-1:0]  cfg_wdata_i = '0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_req_t   in_req_i    = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_rsp_t  out_rsp_o;

  // Region copy and bin stores of the predictor.
  logic [CoordW-1:0] roi_left, roi_right, roi_top, roi_bottom;
  logic [BinW-1:0]   col_bins [MaxWidth];
  logic [BinW-1:0]   row_bins [MaxHeight];

  // Bin reads still owed by the block, oldest first.
  out_rsp_t pending_reads [$];
  int       error_count = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;

  // One directed request, with its result typed in where it is obvious.
  typedef struct {
    in_req_t  req;
    bit       typed;
    out_rsp_t rsp;
  } dir_row_t;
  dir_row_t dir_rows [$];

  roi_projection_histogram_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #ClkHalfNs clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #TimeoutNs;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Histogram predictor: applies one request and returns 1 with the bin read, if any.
  function automatic bit histogram_step(input in_req_t r, output out_rsp_t rsp);
    int unsigned cx;
    int unsigned ry;
    rsp = '0;
    case (r.kind)
      KIND_PIXEL: begin
        if (r.pixel_value != '0 && r.pixel_x >= roi_left && r.pixel_x <= roi_right &&
            r.pixel_y >= roi_top && r.pixel_y <= roi_bottom) begin
          cx = 32'(r.pixel_x) - 32'(roi_left);
          ry = 32'(r.pixel_y) - 32'(roi_top);
          if (cx < MaxWidth && ry < MaxHeight) begin
            if (col_bins[ColAw'(cx)] != BinFull)
              col_bins[ColAw'(cx)] = col_bins[ColAw'(cx)] + 1'b1;
            if (row_bins[RowAw'(ry)] != BinFull)
              row_bins[RowAw'(ry)] = row_bins[RowAw'(ry)] + 1'b1;
          end
        end
        return 1'b0;
      end
      KIND_CLEAR: begin
        foreach (col_bins[i]) col_bins[i] = '0;
        foreach (row_bins[i]) row_bins[i] = '0;
        return 1'b0;
      end
      KIND_READ_COL: begin
        rsp.bin_count = (r.bin_select < MaxWidth) ? col_bins[r.bin_select] : '0;
        rsp.bin_axis  = 1'b0;
        return 1'b1;
      end
      default: begin
        rsp.bin_count = (r.bin_select < MaxHeight) ? row_bins[r.bin_select] : '0;
        rsp.bin_axis  = 1'b1;
        return 1'b1;
      end
    endcase
  endfunction

  // Offer one request after a random gap and record what it should return.
  task automatic send_req(input in_req_t r, input bit typed, input out_rsp_t typed_rsp);
    out_rsp_t rsp;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    if (histogram_step(r, rsp)) pending_reads.push_back(typed ? typed_rsp : rsp);
  endtask

  // Let every owed read arrive, then leave room for a clearing pass to finish.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (ClearWaitCycles) @(posedge clk_i);
  endtask

  // Write all four region registers plus one write to an unused index.
  task automatic set_region(input logic [CoordW-1:0] l, r, t, b);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_ROI_LEFT;
    cfg_wdata_i <= l;
    @(posedge clk_i);
    cfg_idx_i   <= REG_ROI_RIGHT;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_idx_i   <= REG_ROI_TOP;
    cfg_wdata_i <= t;
    @(posedge clk_i);
    cfg_idx_i   <= REG_ROI_BOTTOM;
    cfg_wdata_i <= b;
    @(posedge clk_i);
    cfg_idx_i   <= CfgIdxW'($urandom_range((1 << CfgIdxW) - 1, FirstUnusedReg));
    cfg_wdata_i <= CoordW'($urandom_range(CoordMax));
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    roi_left   = l;
    roi_right  = r;
    roi_top    = t;
    roi_bottom = b;
  endtask

  // Coordinate mostly around the region edges, sometimes anywhere.
  function automatic logic [CoordW-1:0] near_region(input int unsigned lo, hi);
    int unsigned a;
    int unsigned b;
    a = (lo <= hi) ? lo : hi;
    b = (lo <= hi) ? hi : lo;
    a = (a >= 2) ? a - 2 : 0;
    b = (b + 2 > CoordMax) ? CoordMax : b + 2;
    if ($urandom_range(99) < 80) return CoordW'($urandom_range(b, a));
    return CoordW'($urandom_range(CoordMax));
  endfunction

  // Bin offset mostly inside the region span so reads see live counts.
  function automatic logic [CoordW-1:0] near_bins(input int unsigned lo, hi);
    int unsigned span;
    if (lo <= hi && $urandom_range(99) < 80) begin
      span = (hi - lo + 1 > CoordMax) ? CoordMax : hi - lo + 1;
      return CoordW'($urandom_range(span));
    end
    return CoordW'($urandom_range(CoordMax));
  endfunction

  // Mostly pixels aimed at the region, a good share of reads, rare clears.
  function automatic in_req_t random_req();
    in_req_t     r;
    int unsigned pick;
    r.kind        = KIND_PIXEL;
    r.pixel_value = PixelW'($urandom_range(255));
    r.pixel_x     = CoordW'($urandom_range(CoordMax));
    r.pixel_y     = CoordW'($urandom_range(CoordMax));
    r.bin_select  = CoordW'($urandom_range(CoordMax));
    pick = $urandom_range(127);
    if (pick == 0) begin
      r.kind = KIND_CLEAR;
    end else if (pick < 84) begin
      case ($urandom_range(7))
        0: r.pixel_value = '0;
        1: r.pixel_value = '1;
        default: r.pixel_value = PixelW'($urandom_range(255, 1));
      endcase
      r.pixel_x = near_region(32'(roi_left), 32'(roi_right));
      r.pixel_y = near_region(32'(roi_top), 32'(roi_bottom));
    end else if (pick < 106) begin
      r.kind       = KIND_READ_COL;
      r.bin_select = near_bins(32'(roi_left), 32'(roi_right));
    end else begin
      r.kind       = KIND_READ_ROW;
      r.bin_select = near_bins(32'(roi_top), 32'(roi_bottom));
    end
    return r;
  endfunction

  task automatic run_phase(input logic [CoordW-1:0] l, r, t, b,
                           input int send_pct, recv_pct, n);
    set_region(l, r, t, b);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < n; i++) send_req(random_req(), 1'b0, '0);
    wait_idle();
  endtask

  task automatic add_row(input kind_e k, input logic [PixelW-1:0] v,
                         input logic [CoordW-1:0] x, y, s,
                         input bit typed, input logic [BinW-1:0] cnt);
    dir_row_t row;
    row.req.kind        = k;
    row.req.pixel_value = v;
    row.req.pixel_x     = x;
    row.req.pixel_y     = y;
    row.req.bin_select  = s;
    row.typed           = typed;
    row.rsp.bin_count   = cnt;
    row.rsp.bin_axis    = (k == KIND_READ_ROW);
    dir_rows.push_back(row);
  endtask

  // Result checker; the receiver stalls at random in the same process.
  always @(posedge clk_i) begin : bin_monitor
    out_rsp_t want;
    if (out_valid_o && out_ready_i) begin
      if (pending_reads.size() == 0) begin
        report_mismatch($sformatf("unexpected result count %0d axis %0d",
                                  out_rsp_o.bin_count, out_rsp_o.bin_axis));
      end else begin
        want = pending_reads.pop_front();
        if (out_rsp_o.bin_count !== want.bin_count)
          report_mismatch($sformatf("bin_count got %0d expected %0d",
                                    out_rsp_o.bin_count, want.bin_count));
        if (out_rsp_o.bin_axis !== want.bin_axis)
          report_mismatch($sformatf("bin_axis got %0d expected %0d",
                                    out_rsp_o.bin_axis, want.bin_axis));
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin : stimulus
    logic [CoordW-1:0] l, t;
    in_req_t           sat_req;

    // Predictor starts from the reset state of the block.
    roi_left   = '0;
    roi_right  = CoordEdge;
    roi_top    = '0;
    roi_bottom = CoordEdge;
    foreach (col_bins[i]) col_bins[i] = '0;
    foreach (row_bins[i]) row_bins[i] = '0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    // Directed requests with the reset region: empty bins, corners, clear, ignored fields.
    add_row(KIND_READ_COL, '0,      '0,        '0,        '0,        1'b1, '0);
    add_row(KIND_READ_ROW, '1,      '1,        '1,        CoordEdge, 1'b1, '0);
    add_row(KIND_READ_COL, '0,      '0,        '0,        CoordEdge, 1'b1, '0);
    add_row(KIND_PIXEL,    '0,      '0,        '0,        '0,        1'b0, '0);
    add_row(KIND_PIXEL,    '1,      '0,        '0,        '0,        1'b0, '0);
    add_row(KIND_PIXEL,    8'd1,    CoordEdge, CoordEdge, '1,        1'b0, '0);
    add_row(KIND_PIXEL,    8'd128,  CoordEdge, '0,        '1,        1'b0, '0);
    add_row(KIND_PIXEL,    '1,      '0,        CoordEdge, '0,        1'b0, '0);
    add_row(KIND_READ_COL, '1,      '1,        '1,        '0,        1'b0, '0);
    add_row(KIND_READ_COL, '0,      '0,        '0,        CoordEdge, 1'b0, '0);
    add_row(KIND_READ_ROW, '0,      '0,        '0,        '0,        1'b0, '0);
    add_row(KIND_READ_ROW, '0,      '0,        '0,        CoordEdge, 1'b0, '0);
    add_row(KIND_PIXEL,    '0,      '0,        '0,        '0,        1'b0, '0);
    add_row(KIND_READ_COL, '0,      '0,        '0,        '0,        1'b0, '0);
    add_row(KIND_CLEAR,    '1,      '1,        '1,        '1,        1'b0, '0);
    add_row(KIND_READ_COL, '0,      '0,        '0,        '0,        1'b1, '0);
    add_row(KIND_READ_ROW, '0,      '0,        '0,        CoordEdge, 1'b1, '0);
    add_row(KIND_PIXEL,    8'd1,    10'd512,   10'd511,   '0,        1'b0, '0);
    add_row(KIND_READ_COL, '0,      '0,        '0,        10'd512,   1'b0, '0);
    add_row(KIND_READ_ROW, '0,      '0,        '0,        10'd511,   1'b0, '0);
    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
    wait_idle();

    // Random phases over several regions, including empty and single-bin ones.
    run_phase('0, CoordEdge, '0, CoordEdge, 0, 0, 60);
    run_phase(10'd100, 10'd107, 10'd200, 10'd203, 67, 0, 60);
    run_phase(CoordEdge, CoordEdge, CoordEdge, CoordEdge, 0, 67, 50);
    run_phase('0, '0, '0, '0, 16, 16, 50);
    run_phase(10'd600, 10'd500, 10'd10, 10'd20, 67, 0, 40);
    run_phase(10'd10, 10'd20, 10'd900, 10'd100, 0, 67, 40);
    l = CoordW'($urandom_range(CoordMax));
    t = CoordW'($urandom_range(CoordMax));
    run_phase(l, CoordW'($urandom_range(CoordMax, l)), t, CoordW'($urandom_range(CoordMax, t)),
              0, 0, 50);
    l = CoordW'($urandom_range(CoordMax - 16));
    t = CoordW'($urandom_range(CoordMax - 16));
    run_phase(l, l + CoordW'($urandom_range(15)), t, t + CoordW'($urandom_range(15)),
              16, 16, 50);

    // Saturation: hammer one bin on each axis past full, then read both.
    set_region('0, CoordEdge, '0, CoordEdge);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    sat_req = '0;
    sat_req.kind        = KIND_PIXEL;
    sat_req.pixel_value = 8'd1;
    sat_req.pixel_x     = 10'd333;
    sat_req.pixel_y     = 10'd777;
    for (int i = 0; i < SatPixels; i++) send_req(sat_req, 1'b0, '0);
    sat_req.kind       = KIND_READ_COL;
    sat_req.bin_select = 10'd333;
    send_req(sat_req, 1'b0, '0);
    sat_req.kind       = KIND_READ_ROW;
    sat_req.bin_select = 10'd777;
    send_req(sat_req, 1'b0, '0);
    in_valid_i <= 1'b0;

    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
